FILE: hdl/pwsem_pkg.sv
// shared types, codes and constants for the priority wake counting semaphore
package pwsem_pkg;

  // default number of task slots
  localparam int TASKS_DEF = 8;

  // fixed field widths
  localparam int COUNT_W  = 16;
  localparam int PRIO_W   = 8;
  localparam int TID_W    = 3;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  // register reset values
  localparam logic [COUNT_W-1:0] INIT_COUNT_RST = 16'd0;
  localparam logic [COUNT_W-1:0] MAX_COUNT_RST  = 16'd1;

  // waiter priority that give never picks
  localparam logic [PRIO_W-1:0] PRIO_NEVER = 8'hFF;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TAKE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GIVE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESUME = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FAILED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;

  // register indexes
  localparam logic REG_INITIAL_COUNT = 1'b0;
  localparam logic REG_MAX_COUNT     = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_give;
    logic scan_last;
  } sts_t;

endpackage

FILE: hdl/pwsem_ctrl.sv
// controller state machine: sequences load, waiter scan and execute
module pwsem_ctrl import pwsem_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.exec      = 1'b0;
    busy          = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.in_give ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/pwsem_dpath.sv
// datapath: permit count, blocked mask, waiter priorities, scan and result registers
module pwsem_dpath import pwsem_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output sts_t                sts,
  // register values
  input  logic                cfg_init,
  input  logic [COUNT_W-1:0]  initial_count,
  input  logic [COUNT_W-1:0]  max_count,
  // request item
  input  logic [REQ_W-1:0]    req_type,
  input  logic [TID_W-1:0]    task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  input  logic                wait_allowed,
  // result item
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                woken_valid,
  output logic [TID_W-1:0]    woken_task,
  output logic                switch_request,
  output logic [COUNT_W-1:0]  count_now
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;

  // latched request
  logic [REQ_W-1:0]  req_q;
  logic [TID_W-1:0]  tid_q;
  logic [PRIO_W-1:0] prio_q;
  logic              wait_q;

  // semaphore state
  logic [COUNT_W-1:0] permit_count;
  logic [TASKS-1:0]   blocked_mask;
  logic [PRIO_W-1:0]  waiter_priority [TASKS];

  // scan state
  logic [IW-1:0]     scan_idx;
  logic [IW-1:0]     best_idx;
  logic [PRIO_W-1:0] best_prio;
  logic              found;

  logic          tid_ok;
  logic [IW-1:0] tid_idx;
  logic          tid_blocked;
  logic          scan_hit;

  assign tid_ok      = 32'(tid_q) < TASKS;
  assign tid_idx     = IW'(tid_q);
  assign tid_blocked = blocked_mask[tid_idx];
  assign scan_hit    = blocked_mask[scan_idx] && (waiter_priority[scan_idx] < best_prio);

  assign sts.in_give   = (req_type == REQ_GIVE);
  assign sts.scan_last = (scan_idx == IW'(TASKS - 1));

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req_type;
      tid_q  <= task_id;
      prio_q <= task_priority;
      wait_q <= wait_allowed;
    end
  end

  // waiter scan, one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_idx  <= '0;
      best_idx  <= '0;
      best_prio <= PRIO_NEVER;
      found     <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + IW'(1);
      if (scan_hit) begin
        best_idx  <= scan_idx;
        best_prio <= waiter_priority[scan_idx];
        found     <= 1'b1;
      end
    end
  end

  // waiter priority store, written when a task blocks
  always_ff @(posedge clk) begin
    if (cmd.exec && req_q == REQ_TAKE && permit_count == '0 && wait_q && tid_ok) begin
      waiter_priority[tid_idx] <= prio_q;
    end
  end

  // count, mask and result update
  always_ff @(posedge clk) begin
    if (rst) begin
      permit_count <= INIT_COUNT_RST;
      blocked_mask <= '0;
      done         <= 1'b0;
    end else if (cfg_init) begin
      permit_count <= initial_count;
      blocked_mask <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        status         <= ST_FAILED;
        woken_valid    <= 1'b0;
        woken_task     <= '0;
        switch_request <= 1'b0;
        count_now      <= permit_count;
        case (req_q)
          REQ_TAKE: begin
            if (permit_count != '0) begin
              permit_count <= permit_count - COUNT_W'(1);
              count_now    <= permit_count - COUNT_W'(1);
              status       <= ST_GRANTED;
            end else if (wait_q && tid_ok) begin
              blocked_mask[tid_idx] <= 1'b1;
              status                <= ST_BLOCKED;
              switch_request        <= 1'b1;
            end
          end
          REQ_GIVE: begin
            if (found) begin
              blocked_mask[best_idx] <= 1'b0;
              status                 <= ST_WOKEN;
              woken_valid            <= 1'b1;
              woken_task             <= TID_W'(best_idx);
              switch_request         <= 1'b1;
            end else begin
              status <= ST_RELEASED;
              if (permit_count < max_count) begin
                permit_count <= permit_count + COUNT_W'(1);
                count_now    <= permit_count + COUNT_W'(1);
              end
            end
          end
          REQ_RESUME: begin
            if (tid_ok) begin
              if (tid_blocked) begin
                blocked_mask[tid_idx] <= 1'b0;
              end else begin
                status <= ST_GRANTED;
              end
            end
          end
          default: begin
            status <= ST_FAILED;
          end
        endcase
      end
    end
  end

endmodule

FILE: hdl/priority_wake_counting_semaphore.sv
// top level: register port, controller and datapath of the semaphore
// sequence: take, resume and unused requests go from load to execute, and the result is registered;
//   a give first scans one task slot a cycle up to the last slot, then executes
// busy stays high until the execute state is done; no new item is taken before then
// the result strobe done lasts one cycle and the receiver cannot stall
// reset: count 0, no blocked tasks, initial_count 0, max_count 1; waiter priorities
//   hold no value until a task blocks; writing initial_count reloads the count
module priority_wake_counting_semaphore import pwsem_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request item
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [TID_W-1:0]    task_id,
  input  logic [PRIO_W-1:0]   task_priority,
  input  logic                wait_allowed,
  // result item
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                woken_valid,
  output logic [TID_W-1:0]    woken_task,
  output logic                switch_request,
  output logic [COUNT_W-1:0]  count_now
);

  logic [COUNT_W-1:0] initial_count;
  logic [COUNT_W-1:0] max_count;
  logic               wr_en;
  logic               cfg_init;
  cmd_t               cmd;
  sts_t               sts;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign cfg_init = wr_en && (paddr[2] == REG_INITIAL_COUNT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= INIT_COUNT_RST;
      max_count     <= MAX_COUNT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_INITIAL_COUNT: initial_count <= pwdata[COUNT_W-1:0];
        REG_MAX_COUNT:     max_count     <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_INITIAL_COUNT: prdata = 32'(initial_count);
      REG_MAX_COUNT:     prdata = 32'(max_count);
      default:           prdata = '0;
    endcase
  end

  pwsem_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  pwsem_dpath #(
    .TASKS (TASKS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_init       (cfg_init),
    .initial_count  (pwdata[COUNT_W-1:0]),
    .max_count      (max_count),
    .req_type       (req_type),
    .task_id        (task_id),
    .task_priority  (task_priority),
    .wait_allowed   (wait_allowed),
    .done           (done),
    .status         (status),
    .woken_valid    (woken_valid),
    .woken_task     (woken_task),
    .switch_request (switch_request),
    .count_now      (count_now)
  );

endmodule
